>>> hdl/dsha_pkg.sv
`timescale 1ns / 1ps

package dsha_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned NumWords = 8;
  localparam int unsigned WinWords = 16;
  localparam int unsigned NumRounds = 64;
  localparam int unsigned CfgW     = 64;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned OutW     = WordW * (NumWords + 1);

  localparam logic [WordW-1:0] PadWord  = 32'h8000_0000;
  localparam logic [WordW-1:0] LenHdr   = 32'd640;
  localparam logic [WordW-1:0] LenDigest = 32'd256;

  typedef logic [NumWords-1:0][WordW-1:0] state_t;
  typedef logic [WinWords-1:0][WordW-1:0] sched_t;

  localparam state_t InitValue = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MID_0_1  = 3'd0,
    CFG_MID_2_3  = 3'd1,
    CFG_MID_4_5  = 3'd2,
    CFG_MID_6_7  = 3'd3,
    CFG_TAIL_0_1 = 3'd4,
    CFG_TAIL_2   = 3'd5
  } cfg_idx_e;

  // Payload of one pipeline stage: the nonce, the running state and the 16-word schedule
  // window, whose word 0 is the message word of the current round.
  typedef struct packed {
    logic [WordW-1:0] nonce;
    state_t           state;
    sched_t           win;
  } data_t;

  typedef struct packed {
    logic  valid;
    data_t data;
  } stage_t;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] big_sigma0(input logic [WordW-1:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [WordW-1:0] big_sigma1(input logic [WordW-1:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [WordW-1:0] small_sigma0(input logic [WordW-1:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WordW-1:0] small_sigma1(input logic [WordW-1:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [WordW-1:0] byte_swap(input logic [WordW-1:0] x);
    byte_swap = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [WordW-1:0] round_k(input logic [5:0] t);
    case (t)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
      default: round_k = '0;
    endcase
  endfunction

endpackage

>>> hdl/dsha_round.sv
`timescale 1ns / 1ps

module dsha_round #(
  parameter int unsigned ROUND = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  dsha_pkg::stage_t stage_i,
  output dsha_pkg::stage_t stage_o
);

  localparam logic [dsha_pkg::WordW-1:0] RoundK = dsha_pkg::round_k(ROUND[5:0]);

  logic            valid_q;
  dsha_pkg::data_t data_q, data_d;

  always_comb begin
    logic [dsha_pkg::WordW-1:0] ch, maj, t1, t2;
    dsha_pkg::state_t v;
    dsha_pkg::sched_t w;
    v   = stage_i.data.state;
    w   = stage_i.data.win;
    ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1  = v[7] + dsha_pkg::big_sigma1(v[4]) + ch + RoundK + w[0];
    t2  = dsha_pkg::big_sigma0(v[0]) + maj;

    data_d.nonce    = stage_i.data.nonce;
    data_d.state[0] = t1 + t2;
    data_d.state[1] = v[0];
    data_d.state[2] = v[1];
    data_d.state[3] = v[2];
    data_d.state[4] = v[3] + t1;
    data_d.state[5] = v[4];
    data_d.state[6] = v[5];
    data_d.state[7] = v[6];

    // The window slides by one word; the word sixteen rounds ahead enters at the top.
    for (int i = 0; i < dsha_pkg::WinWords - 1; i++) begin
      data_d.win[i] = w[i+1];
    end
    data_d.win[dsha_pkg::WinWords-1] = w[0] + dsha_pkg::small_sigma0(w[1]) + w[9] +
                                       dsha_pkg::small_sigma1(w[14]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;

endmodule

>>> hdl/dsha_hash.sv
`timescale 1ns / 1ps

module dsha_hash (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  dsha_pkg::stage_t stage_i,
  output dsha_pkg::stage_t stage_o
);

  dsha_pkg::stage_t chain [dsha_pkg::NumRounds+1];

  assign chain[0] = stage_i;

  for (genvar r = 0; r < dsha_pkg::NumRounds; r++) begin : g_round
    dsha_round #(
      .ROUND(r)
    ) u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .stage_i(chain[r]),
      .stage_o(chain[r+1])
    );
  end

  assign stage_o = chain[dsha_pkg::NumRounds];

endmodule

>>> hdl/dsha_join.sv
`timescale 1ns / 1ps

module dsha_join (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  dsha_pkg::state_t midstate_i,
  input  dsha_pkg::stage_t stage_i,
  output dsha_pkg::stage_t stage_o
);

  logic            valid_q;
  dsha_pkg::data_t data_q, data_d;

  // Finish the first hash and lay out the padded digest block for the second.
  always_comb begin
    data_d.nonce = stage_i.data.nonce;
    data_d.state = dsha_pkg::InitValue;
    data_d.win   = '0;
    for (int i = 0; i < dsha_pkg::NumWords; i++) begin
      data_d.win[i] = stage_i.data.state[i] + midstate_i[i];
    end
    data_d.win[dsha_pkg::NumWords]   = dsha_pkg::PadWord;
    data_d.win[dsha_pkg::WinWords-1] = dsha_pkg::LenDigest;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;

endmodule

>>> hdl/double_sha256_nonce_from_midstate.sv
`timescale 1ns / 1ps
// Double SHA-256 of an 80-byte block header, resumed from a midstate.
// Input channel s_axis: one 32-bit nonce per item. Output channel m_axis:
// the nonce echoed plus the eight final hash words, one result per item.
// Before hashing, write the midstate and the three tail words through the
// cfg port (index 0..5). Make these writes only while no item is in flight;
// the block itself does not enforce it.
// A result passes through 64 round stages for the first hash, one stage
// that adds the midstate and builds the second block, 64 round stages for
// the second hash, and the output register that adds the initial value.
// Throughput: one nonce per cycle while s_axis_tready is high, set by the
// unrolled one-round-per-stage pipeline.
// When the receiver stalls, one more result is caught in a skid register,
// after which the whole pipeline holds and s_axis_tready drops; nothing is
// lost or repeated. Reset clears all valid bits and all config registers to 0.
module double_sha256_nonce_from_midstate (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dsha_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [dsha_pkg::CfgW-1:0]         cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [dsha_pkg::WordW-1:0]        s_axis_tdata,  // nonce
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // nonce_echo, digest_word_0, ..., digest_word_7
  output logic [dsha_pkg::OutW-1:0]         m_axis_tdata
);

  localparam int unsigned W = dsha_pkg::WordW;

  logic [dsha_pkg::CfgW-1:0] mid_q [4];
  logic [dsha_pkg::CfgW-1:0] tail01_q;
  logic [W-1:0]              tail2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        mid_q[i] <= '0;
      end
      tail01_q <= '0;
      tail2_q  <= '0;
    end else if (cfg_we_i) begin
      case (dsha_pkg::cfg_idx_e'(cfg_idx_i))
        dsha_pkg::CFG_MID_0_1:  mid_q[0] <= cfg_data_i;
        dsha_pkg::CFG_MID_2_3:  mid_q[1] <= cfg_data_i;
        dsha_pkg::CFG_MID_4_5:  mid_q[2] <= cfg_data_i;
        dsha_pkg::CFG_MID_6_7:  mid_q[3] <= cfg_data_i;
        dsha_pkg::CFG_TAIL_0_1: tail01_q <= cfg_data_i;
        dsha_pkg::CFG_TAIL_2:   tail2_q  <= cfg_data_i[W-1:0];
        default: ;
      endcase
    end
  end

  dsha_pkg::state_t midstate;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      midstate[2*i]   = mid_q[i][2*W-1:W];
      midstate[2*i+1] = mid_q[i][W-1:0];
    end
  end

  logic en;
  logic skid_v_q, skid_v_d;
  logic out_v_q, out_v_d;
  logic [dsha_pkg::OutW-1:0] skid_data_q, out_data_q, out_data_d, pipe_data;
  logic pipe_v, out_load;

  // The pipeline moves as long as the skid register is free.
  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  dsha_pkg::stage_t head, h1_out, join_out, h2_out;

  always_comb begin
    head.valid      = s_axis_tvalid;
    head.data.nonce = s_axis_tdata;
    head.data.state = midstate;
    head.data.win   = '0;
    head.data.win[0] = tail01_q[2*W-1:W];
    head.data.win[1] = tail01_q[W-1:0];
    head.data.win[2] = tail2_q;
    head.data.win[3] = dsha_pkg::byte_swap(s_axis_tdata);
    head.data.win[4] = dsha_pkg::PadWord;
    head.data.win[dsha_pkg::WinWords-1] = dsha_pkg::LenHdr;
  end

  dsha_hash u_hash1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .stage_i(head),
    .stage_o(h1_out)
  );

  dsha_join u_join (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .midstate_i(midstate),
    .stage_i   (h1_out),
    .stage_o   (join_out)
  );

  dsha_hash u_hash2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .stage_i(join_out),
    .stage_o(h2_out)
  );

  always_comb begin
    pipe_v = h2_out.valid & en;
    pipe_data[W-1:0] = h2_out.data.nonce;
    for (int i = 0; i < dsha_pkg::NumWords; i++) begin
      pipe_data[W*(i+1) +: W] = h2_out.data.state[i] + dsha_pkg::InitValue[i];
    end
  end

  always_comb begin
    out_load   = !out_v_q || m_axis_tready;
    out_v_d    = out_v_q;
    skid_v_d   = skid_v_q;
    out_data_d = pipe_data;
    if (out_load) begin
      if (skid_v_q) begin
        out_v_d    = 1'b1;
        out_data_d = skid_data_q;
        skid_v_d   = 1'b0;
      end else begin
        out_v_d = pipe_v;
      end
    end else if (pipe_v) begin
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
    end
    if (!out_load && pipe_v) begin
      skid_data_q <= pipe_data;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds an item while the output register is empty");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !m_axis_tready |=> skid_v_q)
    else $error("skid item dropped while the receiver stalls");

  a_stall_catch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    h2_out.valid && en && out_v_q && !m_axis_tready |=> skid_v_q)
    else $error("finished item not caught in the skid register");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && m_axis_tready |=> out_v_q && !skid_v_q)
    else $error("skid register did not move to the output");
`endif

endmodule
